// ===== rtl/dar_pkg.sv =====
// ----------------------------------------------------------------------------
// dar_pkg
// Shared widths, constants, register indexes and types of the decimating
// acceleration record quantizer.
// ----------------------------------------------------------------------------
package dar_pkg;

  // Input and output words
  localparam int IN_W   = 96;   // accel_long, accel_lat, road_speed
  localparam int OUT_W  = 48;   // 44 bits of fields, zero padded
  localparam int SAMP_W = 32;

  // Configuration registers
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 27;
  localparam int RATE_W     = 10;
  localparam int IRATE_W    = 16;
  localparam int STEP_W     = 20;
  localparam int FS_W       = 27;
  localparam int HIST_W     = 16;

  localparam logic [RATE_W-1:0]  RATE_RST  = 10'd4;
  localparam logic [IRATE_W-1:0] IRATE_RST = 16'd833;
  localparam logic [STEP_W-1:0]  STEP_RST  = 20'd4903;
  localparam logic [FS_W-1:0]    FS_RST    = 27'd490333;
  localparam logic [HIST_W-1:0]  HIST_RST  = 16'd5000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RECORD_RATE = 3'd0,
    REG_INPUT_RATE  = 3'd1,
    REG_QUANT_STEP  = 3'd2,
    REG_FULL_SCALE  = 3'd3,
    REG_HISTORY_MS  = 3'd4
  } cfg_reg_t;

  // Decimator
  localparam int ACC_W = 17;

  // Ring
  localparam int DEPTH_DEF = 32;
  localparam int SLOT_W    = 5;
  localparam int FILLED_W  = 6;
  localparam int MS_PER_S  = 1000;

  // Acceleration quantizer
  localparam int QNUM_W = FS_W + 1;   // magnitude plus half a step
  localparam int CODE_W = 8;
  localparam logic [CODE_W-1:0] CODE_MAX = 8'sd127;
  localparam logic [CODE_W-1:0] CODE_MIN = 8'h80;

  // Speed: mm/s * 36 / 1000 gives 0.1 km/h
  localparam int SPD_W       = 16;
  localparam int SPD_PROD_W  = 37;
  localparam int SPD_NUM_W   = 26;
  localparam int SPD_DIV     = 1000;
  localparam logic [SPD_PROD_W-1:0] SPD_SAT_PROD = 37'd65536000;
  localparam logic [SPD_W-1:0]      SPD_MAX      = 16'hFFFF;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_WRAP
  } state_t;

  typedef struct packed {
    logic              busy;
    logic              clip;
    logic [CODE_W-1:0] code;
  } lane_res_t;

endpackage

// ===== rtl/dar_udiv.sv =====
// ----------------------------------------------------------------------------
// dar_udiv
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dar_udiv
  import dar_pkg::*;
#(
  parameter int N_W = 8,
  parameter int D_W = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic           busy,
  output logic [N_W-1:0] quot,
  output logic [D_W-1:0] rem
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [N_W-1:0]   quo_r, quo_nxt;
  logic [D_W-1:0]   rem_r, rem_nxt;
  logic [D_W-1:0]   den_r, den_nxt;
  logic [D_W:0]     trial, diff;
  logic             ge;

  always_comb begin
    trial = {rem_r, quo_r[N_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});

    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(N_W);
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      // shift the next numerator bit in, keep the quotient bit
      rem_nxt  = ge ? diff[D_W-1:0] : trial[D_W-1:0];
      quo_nxt  = N_W'({quo_r, ge});
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/dar_quant_lane.sv =====
// ----------------------------------------------------------------------------
// dar_quant_lane
// One acceleration axis: clamp to full scale, divide by the step with
// rounding half away from zero, saturate to a signed byte.
// ----------------------------------------------------------------------------
module dar_quant_lane
  import dar_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SAMP_W-1:0] accel,
  input  logic [FS_W-1:0]   full_scale,
  input  logic [STEP_W-1:0] quant_step,
  output lane_res_t         res
);

  logic signed [SAMP_W:0] a_s, fs_s, mag_s;
  logic                   over_hi, over_lo, neg;
  logic [FS_W-1:0]        mag;
  logic [STEP_W-1:0]      lsb;
  logic [QNUM_W-1:0]      num;
  logic                   neg_r, clip_r;
  logic                   div_busy;
  logic [QNUM_W-1:0]      quot;
  logic [STEP_W-1:0]      rem_unused;

  always_comb begin
    a_s     = {accel[SAMP_W-1], accel};
    fs_s    = signed'({{(SAMP_W + 1 - FS_W){1'b0}}, full_scale});
    over_hi = (a_s > fs_s);
    over_lo = (a_s < -fs_s);
    neg     = accel[SAMP_W-1];
    mag_s   = neg ? -a_s : a_s;
    mag     = (over_hi || over_lo) ? full_scale : mag_s[FS_W-1:0];
    lsb     = (quant_step == '0) ? STEP_W'(1) : quant_step;
    num     = {1'b0, mag} + QNUM_W'(lsb >> 1);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= neg;
      clip_r <= over_hi || over_lo;
    end
  end

  dar_udiv #(
    .N_W (QNUM_W),
    .D_W (STEP_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .num   (num),
    .den   (lsb),
    .busy  (div_busy),
    .quot  (quot),
    .rem   (rem_unused)
  );

  always_comb begin
    res.busy = div_busy;
    res.clip = clip_r;
    if (neg_r) begin
      res.code = (quot > QNUM_W'(128)) ? CODE_MIN : CODE_W'(-quot[CODE_W-1:0]);
    end else begin
      res.code = (quot > QNUM_W'(127)) ? CODE_MAX : quot[CODE_W-1:0];
    end
  end

endmodule

// ===== rtl/dar_merge.sv =====
// ----------------------------------------------------------------------------
// dar_merge
// Combines the lane results with the ring head and fill level into one
// record word and holds it in the output register.
// ----------------------------------------------------------------------------
module dar_merge
  import dar_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               commit,
  input  logic [$clog2(DEPTH + 1)-1:0]       cap,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] head_new,
  input  lane_res_t                          long_res,
  input  lane_res_t                          lat_res,
  input  logic [SPD_W-1:0]                   speed,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [OUT_W-1:0]                   out_tdata,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] head,
  output logic                               out_free
);

  localparam int HEAD_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [HEAD_W-1:0]   head_r;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic                valid_r, valid_nxt;
  logic [OUT_W-1:0]    data_r;

  always_comb begin
    fill_nxt  = (fill_r < cap) ? fill_r + FILL_W'(1) : fill_r;
    valid_nxt = valid_r;
    if (commit) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      fill_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (commit) begin
        head_r <= head_new;
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      data_r <= {{(OUT_W - SLOT_W - 2 * CODE_W - 1 - SPD_W - FILLED_W){1'b0}},
                 FILLED_W'(fill_nxt), speed, long_res.clip | lat_res.clip,
                 lat_res.code, long_res.code, SLOT_W'(head_new)};
    end
  end

  assign out_free   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign head       = head_r;

endmodule

// ===== rtl/decimating_accel_record_quantizer.sv =====
// ----------------------------------------------------------------------------
// decimating_accel_record_quantizer
// Fractional decimator feeding saturating acceleration quantizers and a
// speed scaler; each emitted record takes the next slot of a ring.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata: long, lat, speed
//  out_    | out | out_tvalid/out_tready| out_tdata: one record word
//  cfg_    | in  | cfg_we               | cfg_addr, cfg_wdata
//
//  A word that emits no record is taken while the control stays idle. A record
//  is worked out first by the 28-bit quantizer dividers, then by the slot
//  modulo divider. One record is worked on at a time; a finished record
//  waits in the output register while the next word is taken. rst_n is
//  synchronous, active low.
// ----------------------------------------------------------------------------
module decimating_accel_record_quantizer
  import dar_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // [31:0] accel_long, [63:32] accel_lat,
                                            // [95:64] road_speed
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // [4:0] slot, [12:5] long_code,
                                            // [20:13] lat_code, [21] clipped,
                                            // [37:22] speed_tenths_kph,
                                            // [43:38] filled, [47:44] zero
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int HEAD_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int SPAN_LIM = DEPTH * MS_PER_S;
  localparam int SPAN_W = $clog2(SPAN_LIM);
  localparam int PROD_W = HIST_W + RATE_W;

  // Divide by 1000 as a reciprocal multiply; a shift of the numerator width
  // plus ten bits keeps the quotient exact over the whole numerator range
  localparam int     SPD_K      = SPD_NUM_W + $clog2(SPD_DIV);
  localparam int     SPD_MUL_W  = SPD_K + SPD_W;
  localparam longint SPD_RCP    = ((longint'(1) << SPD_K) + SPD_DIV - 1) / SPD_DIV;
  localparam int     SPAN_K     = SPAN_W + $clog2(MS_PER_S);
  localparam int     SPAN_MUL_W = SPAN_K + FILL_W;
  localparam longint SPAN_RCP   = ((longint'(1) << SPAN_K) + MS_PER_S - 1) / MS_PER_S;

  // Configuration
  logic [RATE_W-1:0]  rate_r;
  logic [IRATE_W-1:0] irate_r;
  logic [STEP_W-1:0]  step_r;
  logic [FS_W-1:0]    fs_r;
  logic [HIST_W-1:0]  hist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= RATE_RST;
      irate_r <= IRATE_RST;
      step_r  <= STEP_RST;
      fs_r    <= FS_RST;
      hist_r  <= HIST_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_RECORD_RATE: rate_r  <= cfg_wdata[RATE_W-1:0];
        REG_INPUT_RATE:  irate_r <= cfg_wdata[IRATE_W-1:0];
        REG_QUANT_STEP:  step_r  <= cfg_wdata[STEP_W-1:0];
        REG_FULL_SCALE:  fs_r    <= cfg_wdata[FS_W-1:0];
        REG_HISTORY_MS:  hist_r  <= cfg_wdata[HIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Control
  state_t state_r, state_nxt;
  logic   accept, hit, launch, calc_done, start_mod, commit;
  logic   out_free;

  logic [ACC_W-1:0] phase_r, phase_nxt, acc_sum;

  logic [SAMP_W-1:0] sp;
  logic [SPD_PROD_W-1:0] spd_prod;
  logic spd_zero, spd_sat, spd_zero_r, spd_sat_r;
  logic [PROD_W-1:0] span_prod;
  logic span_sat, span_sat_r;

  lane_res_t long_res, lat_res;
  logic mod_busy;
  logic [SPD_NUM_W-1:0] spd_num_r;
  logic [SPD_MUL_W-1:0] spd_mul;
  logic [SPAN_W-1:0] span_num_r;
  logic [SPAN_MUL_W-1:0] span_mul;
  logic [FILL_W-1:0] span_q;
  logic [FILL_W-1:0] cap, mod_num, mod_q_unused, mod_rem;
  logic [HEAD_W-1:0] head;
  logic [SPD_W-1:0] speed;

  always_comb begin
    accept    = in_tvalid && in_tready;
    acc_sum   = phase_r + ACC_W'(rate_r);
    hit       = (acc_sum >= ACC_W'(irate_r));
    launch    = accept && hit;
    phase_nxt = phase_r;
    if (accept) begin
      phase_nxt = hit ? acc_sum - ACC_W'(irate_r) : acc_sum;
    end
  end

  always_comb begin
    calc_done = !long_res.busy && !lat_res.busy;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (launch) state_nxt = S_CALC;
      S_CALC: if (calc_done) state_nxt = S_WRAP;
      S_WRAP: if (!mod_busy && out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == S_IDLE);
    start_mod = (state_r == S_CALC) && calc_done;
    commit    = (state_r == S_WRAP) && !mod_busy && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Speed and capacity pre-checks; negative or zero speeds and saturated cases skip the divide result
  always_comb begin
    sp        = in_tdata[3*SAMP_W-1:2*SAMP_W];
    spd_prod  = (SPD_PROD_W'(sp[SAMP_W-2:0]) << 5) + (SPD_PROD_W'(sp[SAMP_W-2:0]) << 2);
    spd_zero  = sp[SAMP_W-1] || (sp == '0);
    spd_sat   = (spd_prod >= SPD_SAT_PROD);
    span_prod = PROD_W'(hist_r) * PROD_W'(rate_r);
    span_sat  = (span_prod >= PROD_W'(SPAN_LIM));
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      spd_zero_r <= spd_zero;
      spd_sat_r  <= spd_sat;
      span_sat_r <= span_sat;
      spd_num_r  <= spd_prod[SPD_NUM_W-1:0];
      span_num_r <= span_prod[SPAN_W-1:0];
    end
  end

  dar_quant_lane u_lane_long (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (launch),
    .accel      (in_tdata[SAMP_W-1:0]),
    .full_scale (fs_r),
    .quant_step (step_r),
    .res        (long_res)
  );

  dar_quant_lane u_lane_lat (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (launch),
    .accel      (in_tdata[2*SAMP_W-1:SAMP_W]),
    .full_scale (fs_r),
    .quant_step (step_r),
    .res        (lat_res)
  );

  always_comb begin
    spd_mul  = SPD_MUL_W'(spd_num_r) * SPD_MUL_W'(SPD_RCP);
    span_mul = SPAN_MUL_W'(span_num_r) * SPAN_MUL_W'(SPAN_RCP);
    span_q   = span_mul[SPAN_K +: FILL_W];
    if (spd_zero_r) begin
      speed = '0;
    end else if (spd_sat_r) begin
      speed = SPD_MAX;
    end else begin
      speed = spd_mul[SPD_K +: SPD_W];
    end
    // capacity of zero is taken as one slot
    cap = span_sat_r ? FILL_W'(DEPTH) : span_q;
    if (cap == '0) begin
      cap = FILL_W'(1);
    end
    mod_num = FILL_W'(head) + FILL_W'(1);
  end

  // Next slot: (head + 1) mod capacity
  dar_udiv #(
    .N_W (FILL_W),
    .D_W (FILL_W)
  ) u_div_slot (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_mod),
    .num   (mod_num),
    .den   (cap),
    .busy  (mod_busy),
    .quot  (mod_q_unused),
    .rem   (mod_rem)
  );

  dar_merge #(
    .DEPTH (DEPTH)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .commit     (commit),
    .cap        (cap),
    .head_new   (HEAD_W'(mod_rem)),
    .long_res   (long_res),
    .lat_res    (lat_res),
    .speed      (speed),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .head       (head),
    .out_free   (out_free)
  );

endmodule

// ===== rtl/dar_checker.sv =====
// ----------------------------------------------------------------------------
// dar_checker
// Port-level checks of the record quantizer, bound to the top level.
// ----------------------------------------------------------------------------
module dar_checker
  import dar_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // a stalled record word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("record word changed while stalled");

  // input side closes only after taking a word
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid && in_tready))
    else $error("in_tready dropped without an accepted word");

  // a record cannot appear straight after the word that caused it
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("record appeared one cycle after accept");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_W-1:44] == '0)
    else $error("record padding not zero");

endmodule

bind decimating_accel_record_quantizer dar_checker u_dar_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
